[design/qte_pkg.sv]
// shared types, constants and the arctangent table for the quaternion to euler block
`default_nettype none
package qte_pkg;

  // widths of the internal datapath
  localparam int RW      = 35;  // rotation matrix terms, Q28
  localparam int CW      = 36;  // cordic x / y
  localparam int ZW      = 30;  // cordic angle, 2^-20 degree
  localparam int SQ_BITS = 31;  // bits of the square root result
  localparam int SUM_W   = 62;  // radicand width
  localparam int INT_FRAC = 20;

  // lock codes
  localparam logic [1:0] LOCK_NONE = 2'd0;
  localparam logic [1:0] LOCK_NEG  = 2'd1;
  localparam logic [1:0] LOCK_POS  = 2'd2;

  // 0.9999999 in Q28
  localparam logic signed [RW-1:0] LOCK_LIM = 35'sd268435429;

  localparam logic signed [ZW-1:0] DEG90 = 30'sd94371840;

  // one cordic word moving down the chain
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  // operands riding along with the square root
  typedef struct packed {
    logic signed [CW-1:0] yaw_y;
    logic signed [CW-1:0] yaw_x;
    logic signed [CW-1:0] roll_y;
    logic signed [CW-1:0] roll_x;
    logic signed [CW-1:0] pit_y;
    logic [1:0]           lock;
  } side_t;

  // atan(2^-i) in 2^-20 degree
  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] v;
    begin
      unique case (i)
        0: v = 30'sd47185920;
        1: v = 30'sd27855475;
        2: v = 30'sd14718068;
        3: v = 30'sd7471121;
        4: v = 30'sd3750058;
        5: v = 30'sd1876857;
        6: v = 30'sd938658;
        7: v = 30'sd469357;
        8: v = 30'sd234682;
        9: v = 30'sd117342;
        10: v = 30'sd58671;
        11: v = 30'sd29335;
        12: v = 30'sd14668;
        13: v = 30'sd7334;
        14: v = 30'sd3667;
        15: v = 30'sd1833;
        16: v = 30'sd917;
        17: v = 30'sd458;
        18: v = 30'sd229;
        19: v = 30'sd115;
        20: v = 30'sd57;
        21: v = 30'sd29;
        22: v = 30'sd14;
        23: v = 30'sd7;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

[design/qte_sqrt_cell.sv]
// one bit of the pipelined integer square root
`default_nettype none
module qte_sqrt_cell #(
  parameter int K = 0
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [qte_pkg::SUM_W-1:0]       rem_i,
  input  wire logic [qte_pkg::SQ_BITS-1:0]     root_i,
  output logic      [qte_pkg::SUM_W-1:0]       rem_o,
  output logic      [qte_pkg::SQ_BITS-1:0]     root_o
);

  logic [qte_pkg::SUM_W:0]       trial;
  logic [qte_pkg::SUM_W:0]       rem_ext;
  logic [qte_pkg::SUM_W-1:0]     rem_nxt;
  logic [qte_pkg::SQ_BITS-1:0]   root_nxt;

  // trial = 2 * root * 2^K + 2^2K
  always_comb begin
    trial   = ((qte_pkg::SUM_W+1)'(root_i) << (K + 1))
            + ((qte_pkg::SUM_W+1)'(1) << (2 * K));
    rem_ext = (qte_pkg::SUM_W+1)'(rem_i);
    if (rem_ext >= trial) begin
      rem_nxt  = qte_pkg::SUM_W'(rem_ext - trial);
      root_nxt = root_i | (qte_pkg::SQ_BITS'(1) << K);
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
    end
  end

endmodule
`default_nettype wire

[design/qte_cordic_cell.sv]
// one vectoring iteration of the cordic arctangent
`default_nettype none
module qte_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire qte_pkg::cordic_t d_i,
  output qte_pkg::cordic_t      d_o
);

  qte_pkg::cordic_t d_nxt;
  logic signed [qte_pkg::CW-1:0] xs;
  logic signed [qte_pkg::CW-1:0] ys;

  // rotate toward the x axis with the sign of y
  always_comb begin
    xs = d_i.x >>> STEP;
    ys = d_i.y >>> STEP;
    d_nxt = d_i;
    if (!d_i.y[qte_pkg::CW-1]) begin
      d_nxt.x = d_i.x + ys;
      d_nxt.y = d_i.y - xs;
      d_nxt.z = d_i.z + qte_pkg::atan_tab(STEP);
    end else begin
      d_nxt.x = d_i.x - ys;
      d_nxt.y = d_i.y + xs;
      d_nxt.z = d_i.z - qte_pkg::atan_tab(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule
`default_nettype wire

[design/qte_atan2.sv]
// pipelined atan2: quadrant fold, chain of cordic cells, rounding and clamp
`default_nettype none
module qte_atan2 #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int LIM_DEG         = 180
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [qte_pkg::CW-1:0] y_i,
  input  wire logic signed [qte_pkg::CW-1:0] x_i,
  output logic signed [qte_pkg::ZW-1:0]      ang_o
);

  localparam int SH = qte_pkg::INT_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [qte_pkg::ZW-1:0] LIM = qte_pkg::ZW'(LIM_DEG << ANGLE_FRAC_BITS);
  localparam logic signed [qte_pkg::ZW-1:0] HALF = qte_pkg::ZW'(1 << (SH - 1));

  qte_pkg::cordic_t pre_nxt;
  qte_pkg::cordic_t pre_r;
  qte_pkg::cordic_t chain [0:CORDIC_STEPS];
  logic signed [qte_pkg::ZW-1:0] rnd;

  // fold the left half plane onto the right one
  always_comb begin
    pre_nxt.zero = (x_i == '0) && (y_i == '0);
    pre_nxt.x = x_i;
    pre_nxt.y = y_i;
    pre_nxt.z = '0;
    if (x_i[qte_pkg::CW-1]) begin
      if (!y_i[qte_pkg::CW-1]) begin
        pre_nxt.x = y_i;
        pre_nxt.y = -x_i;
        pre_nxt.z = qte_pkg::DEG90;
      end else begin
        pre_nxt.x = -y_i;
        pre_nxt.y = x_i;
        pre_nxt.z = -qte_pkg::DEG90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= pre_nxt;
    end
  end

  assign chain[0] = pre_r;

  // iteration cells
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    qte_cordic_cell #(.STEP(i)) u_cell (
      .clk (clk),
      .en  (en),
      .d_i (chain[i]),
      .d_o (chain[i+1])
    );
  end

  // round half up to the output scale, then clamp; a zero vector gives zero
  always_comb begin
    rnd = (chain[CORDIC_STEPS].z + HALF) >>> SH;
    if (chain[CORDIC_STEPS].zero) begin
      ang_o = '0;
    end else if (rnd > LIM) begin
      ang_o = LIM;
    end else if (rnd < -LIM) begin
      ang_o = -LIM;
    end else begin
      ang_o = rnd;
    end
  end

endmodule
`default_nettype wire

[design/quaternion_to_euler_angles.sv]
// quaternion to z-y-x euler angles, fully pipelined
//
// Takes one unit quaternion (four signed Q14 words) on the in_ channel and
// returns yaw, pitch and roll in 1/2^ANGLE_FRAC_BITS degree plus a gimbal
// lock code on the out_ channel. Both channels are valid/ready.
// The datapath is a single pipeline: five stages of products, matrix terms
// and squares, a chain of 31 square root cells, one quadrant fold stage and
// CORDIC_STEPS cordic cells, then the output register. One word is taken
// every cycle while the output is not stalled; throughput is set by the
// pipeline, one stage per root bit and per cordic iteration.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; it resumes as soon as the result is taken.
// Reset clears all valid flags; no result is pending afterwards.
`default_nettype none
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_quat_w,
  input  wire logic signed [15:0] in_quat_x,
  input  wire logic signed [15:0] in_quat_y,
  input  wire logic signed [15:0] in_quat_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [16:0]      out_yaw_angle,
  output logic signed [15:0]      out_pitch_angle,
  output logic signed [16:0]      out_roll_angle,
  output logic [1:0]              out_lock_state
);

  localparam int SQ = qte_pkg::SQ_BITS;
  localparam int CW = qte_pkg::CW;
  localparam int RW = qte_pkg::RW;
  localparam int NV = 6 + SQ + CORDIC_STEPS;
  localparam logic signed [qte_pkg::ZW-1:0] P90 = qte_pkg::ZW'(90 << ANGLE_FRAC_BITS);

  logic adv;
  logic [NV-1:0] vld_r;
  logic out_valid_r;

  logic signed [15:0] w1_r, x1_r, y1_r, z1_r;
  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  logic signed [RW-1:0] r11_r, r12_r, r31_r, r32_r, r33_r;
  logic signed [31:0] a_s, b_s;
  logic signed [63:0] sq_a, sq_b;
  logic signed [63:0] sq_a_r, sq_b_r;
  qte_pkg::side_t side4_nxt, side4_r, side5_r;
  logic [qte_pkg::SUM_W-1:0] sum_r;

  logic [qte_pkg::SUM_W-1:0] rem_w  [0:SQ];
  logic [SQ-1:0]             root_w [0:SQ];
  qte_pkg::side_t            side_r [0:SQ-1];
  logic [1:0]                lk_r   [0:CORDIC_STEPS];

  logic signed [qte_pkg::ZW-1:0] yaw_ang, pit_ang, roll_ang;
  logic signed [qte_pkg::ZW-1:0] yaw_sel, pit_sel;

  // pipeline moves whenever the output register is free or being emptied
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv && rst_n;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NV-2:0], in_valid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  // stages 1 to 3: capture, products, matrix terms
  always_ff @(posedge clk) begin
    if (adv) begin
      w1_r <= in_quat_w;
      x1_r <= in_quat_x;
      y1_r <= in_quat_y;
      z1_r <= in_quat_z;
      ww_r <= w1_r * w1_r;
      xx_r <= x1_r * x1_r;
      yy_r <= y1_r * y1_r;
      zz_r <= z1_r * z1_r;
      xy_r <= x1_r * y1_r;
      wz_r <= w1_r * z1_r;
      xz_r <= x1_r * z1_r;
      wy_r <= w1_r * y1_r;
      yz_r <= y1_r * z1_r;
      wx_r <= w1_r * x1_r;
      r11_r <= RW'(ww_r) + RW'(xx_r) - RW'(yy_r) - RW'(zz_r);
      r12_r <= (RW'(xy_r) - RW'(wz_r)) <<< 1;
      r31_r <= (RW'(xz_r) - RW'(wy_r)) <<< 1;
      r32_r <= (RW'(yz_r) + RW'(wx_r)) <<< 1;
      r33_r <= RW'(ww_r) - RW'(xx_r) - RW'(yy_r) + RW'(zz_r);
    end
  end

  // stage 4: lock detect, operand select, squares
  always_comb begin
    a_s  = 32'(r32_r >>> 2);
    b_s  = 32'(r33_r >>> 2);
    sq_a = a_s * a_s;
    sq_b = b_s * b_s;
    if (r31_r > qte_pkg::LOCK_LIM) begin
      side4_nxt.lock = qte_pkg::LOCK_NEG;
    end else if (r31_r < -qte_pkg::LOCK_LIM) begin
      side4_nxt.lock = qte_pkg::LOCK_POS;
    end else begin
      side4_nxt.lock = qte_pkg::LOCK_NONE;
    end
    side4_nxt.yaw_y = CW'(r12_r);
    side4_nxt.yaw_x = CW'(r11_r);
    side4_nxt.pit_y = -CW'(r31_r >>> 2);
    if (side4_nxt.lock != qte_pkg::LOCK_NONE) begin
      side4_nxt.roll_y = -CW'(r12_r);
      side4_nxt.roll_x = CW'(r11_r);
    end else begin
      side4_nxt.roll_y = CW'(r32_r);
      side4_nxt.roll_x = CW'(r33_r);
    end
  end

  // stages 4 and 5: registered squares, then radicand
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_a_r  <= sq_a;
      sq_b_r  <= sq_b;
      side4_r <= side4_nxt;
      sum_r   <= qte_pkg::SUM_W'(sq_a_r) + qte_pkg::SUM_W'(sq_b_r);
      side5_r <= side4_r;
    end
  end

  // square root chain, one result bit per cell, operands ride alongside
  assign rem_w[0]  = sum_r;
  assign root_w[0] = '0;

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    qte_sqrt_cell #(.K(SQ - 1 - j)) u_sqrt (
      .clk    (clk),
      .en     (adv),
      .rem_i  (rem_w[j]),
      .root_i (root_w[j]),
      .rem_o  (rem_w[j+1]),
      .root_o (root_w[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side5_r;
      for (int j = 1; j < SQ; j++) begin
        side_r[j] <= side_r[j-1];
      end
      lk_r[0] <= side_r[SQ-1].lock;
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
        lk_r[k] <= lk_r[k-1];
      end
    end
  end

  // three arctangent pipelines
  qte_atan2 #(
    .CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .LIM_DEG(180)
  ) u_yaw (
    .clk (clk), .en (adv),
    .y_i (side_r[SQ-1].yaw_y), .x_i (side_r[SQ-1].yaw_x),
    .ang_o (yaw_ang)
  );

  qte_atan2 #(
    .CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .LIM_DEG(90)
  ) u_pitch (
    .clk (clk), .en (adv),
    .y_i (side_r[SQ-1].pit_y), .x_i (CW'(root_w[SQ])),
    .ang_o (pit_ang)
  );

  qte_atan2 #(
    .CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .LIM_DEG(180)
  ) u_roll (
    .clk (clk), .en (adv),
    .y_i (side_r[SQ-1].roll_y), .x_i (side_r[SQ-1].roll_x),
    .ang_o (roll_ang)
  );

  // gimbal lock overrides
  always_comb begin
    unique case (lk_r[CORDIC_STEPS])
      qte_pkg::LOCK_NEG: begin
        yaw_sel = '0;
        pit_sel = -P90;
      end
      qte_pkg::LOCK_POS: begin
        yaw_sel = '0;
        pit_sel = P90;
      end
      default: begin
        yaw_sel = yaw_ang;
        pit_sel = pit_ang;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_yaw_angle   <= yaw_sel[16:0];
      out_pitch_angle <= pit_sel[15:0];
      out_roll_angle  <= roll_ang[16:0];
      out_lock_state  <= lk_r[CORDIC_STEPS];
    end
  end

endmodule
`default_nettype wire
